/* design/tsa_pkg.sv */
// Package for the tangent series block: widths, limits, coefficient table and helpers.
// Depends on nothing; the top level and its checker import it.
`default_nettype none

package tsa_pkg;

	// Term count settings
	localparam int MAX_TERMS   = 12;
	localparam int TABLE_TERMS = 12;
	localparam int TERM_LIMIT  = (MAX_TERMS < TABLE_TERMS) ? MAX_TERMS : TABLE_TERMS;
	localparam int NUM_STEPS   = TERM_LIMIT - 1;
	localparam int TERM_W      = 4;
	localparam int TERM_RESET  = 12;

	// Fixed-point widths
	localparam int ANGLE_W   = 32;               // Q2.30 input
	localparam int MAG_W     = 31;               // in-domain magnitude
	localparam int SQ_W      = 2 * MAG_W;        // exact square, Q2.60
	localparam int Y_W       = SQ_W - 4;         // square in Q2.56
	localparam int ACC_W     = 64;               // Horner sum, Q8.56
	localparam int HALF_W    = 32;               // multiplier operand split
	localparam int FRAC_BITS = 56;
	localparam int SUM_W     = ACC_W + Y_W + 1;  // Horner product plus rounding
	localparam int PROD_W    = MAG_W + HALF_W;   // final partial product
	localparam int FSUM_W    = MAG_W + ACC_W + 1;
	localparam int TAN_W     = 40;               // Q10.30 output

	// Pipeline depth from accepting edge to the edge that takes the result
	localparam int LATENCY = 3 * NUM_STEPS + 6;

	localparam logic [ANGLE_W-1:0] DOMAIN_LIMIT = 32'd1686629363;
	localparam logic [TAN_W-1:0]   POS_LIMIT    = 40'h7F_FFFF_FFFF;
	localparam logic [TAN_W-1:0]   NEG_LIMIT    = 40'h80_0000_0000;

	// Exact rational series coefficients of tan(x)/x in powers of x^2
	localparam logic [63:0] COEF_NUM [TABLE_TERMS] = '{
		64'd1, 64'd1, 64'd2, 64'd17, 64'd62, 64'd1382, 64'd21844, 64'd929569,
		64'd6404582, 64'd443861162, 64'd18888466084, 64'd113927491862
	};
	localparam logic [63:0] COEF_DEN [TABLE_TERMS] = '{
		64'd1, 64'd3, 64'd15, 64'd315, 64'd2835, 64'd155925, 64'd6081075,
		64'd638512875, 64'd10854718875, 64'd1856156927625,
		64'd194896477400625, 64'd2900518163668125
	};

	// Item fields that ride along the pipeline with the Horner sum
	typedef struct packed {
		logic             neg;
		logic             ood;
		logic [MAG_W-1:0] ax;
		logic [Y_W-1:0]   y;
	} side_t;

	// Coefficient k as unsigned Q8.56, rounded to nearest; evaluated on constants only
	function automatic logic [ACC_W-1:0] coef_fixed(input int k);
		logic [63:0] den;
		logic [63:0] r;
		logic [63:0] q;
		den = COEF_DEN[k];
		r   = COEF_NUM[k];
		q   = '0;
		// integer bit first, then one fraction bit per pass
		for (int b = 0; b <= FRAC_BITS; b++) begin
			q = q << 1;
			if (r >= den) begin
				r    = r - den;
				q[0] = 1'b1;
			end
			r = r << 1;
		end
		if (r >= den) q = q + 64'd1;
		return q;
	endfunction

endpackage

`default_nettype wire

/* design/tangent_series_approximation.sv */
// Pipeline: the result strobe follows the accepting edge through eleven Horner steps
//   of three stages each, besides the input and output stages.
// Throughput: one angle per cycle; busy stays low since the receiver cannot stall.
// Reset: arst_n clears all valid bits and sets term_count to 12; data registers hold.
// Top level of the tangent series block; uses tsa_pkg for widths, limits and the
// coefficient table.
`default_nettype none

module tangent_series_approximation (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output      logic                        busy,
	input  wire logic                        cfg_we,
	input  wire logic [tsa_pkg::TERM_W-1:0]  cfg_wdata,
	input  wire logic signed [tsa_pkg::ANGLE_W-1:0] angle,
	output      logic                        done,
	output      logic signed [tsa_pkg::TAN_W-1:0] tangent,
	output      logic                        out_of_domain
);
	import tsa_pkg::*;

	// ------------------------------------------------------------------
	// Configuration: term count, clamped to 1..TERM_LIMIT for use.
	// ------------------------------------------------------------------
	logic [TERM_W-1:0] term_count_q;
	logic [TERM_W-1:0] n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_W'(TERM_RESET);
		end else if (cfg_we) begin
			term_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (term_count_q == '0) begin
			n_eff = TERM_W'(1);
		end else if (term_count_q > TERM_W'(TERM_LIMIT)) begin
			n_eff = TERM_W'(TERM_LIMIT);
		end else begin
			n_eff = term_count_q;
		end
	end

	// Every cycle can take a beat: the pipeline never stalls.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// Stage 1: magnitude and domain check. The odd symmetry of tan lets
	// the whole datapath work on |x| and apply the sign at the very end.
	// ------------------------------------------------------------------
	logic [ANGLE_W-1:0] abs_angle;
	assign abs_angle = angle[ANGLE_W-1] ? (~angle + ANGLE_W'(1)) : angle;

	logic             ab_v_s1;
	logic             ab_neg_s1;
	logic             ab_ood_s1;
	logic [MAG_W-1:0] ab_ax_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ab_v_s1 <= 1'b0;
		end else begin
			ab_v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		ab_neg_s1 <= angle[ANGLE_W-1];
		ab_ood_s1 <= abs_angle >= DOMAIN_LIMIT;
		// in-domain magnitudes fit MAG_W bits; out-of-domain beats drop their data
		ab_ax_s1  <= abs_angle[MAG_W-1:0];
	end

	// ------------------------------------------------------------------
	// Stage 2: exact square of the magnitude (one 31 x 31 multiply).
	// ------------------------------------------------------------------
	logic             sq_v_s2;
	logic             sq_neg_s2;
	logic             sq_ood_s2;
	logic [MAG_W-1:0] sq_ax_s2;
	logic [SQ_W-1:0]  sq_sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s2 <= 1'b0;
		end else begin
			sq_v_s2 <= ab_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_neg_s2 <= ab_neg_s1;
		sq_ood_s2 <= ab_ood_s1;
		sq_ax_s2  <= ab_ax_s1;
		sq_sq_s2  <= SQ_W'(ab_ax_s1) * SQ_W'(ab_ax_s1);
	end

	// ------------------------------------------------------------------
	// Stage 3: round the square from Q2.60 to Q2.56 (add half an LSB of
	// the target, drop four bits) and seed the Horner sum. The seed is the
	// top coefficient only when all table terms are in use; otherwise it is
	// zero and the first active step loads its own coefficient.
	// ------------------------------------------------------------------
	localparam logic [ACC_W-1:0] COEF_TOP = coef_fixed(TERM_LIMIT - 1);

	logic [SQ_W-1:0] sq_round;
	assign sq_round = sq_sq_s2 + SQ_W'(8);

	logic             y_v_s3;
	side_t            y_side_s3;
	logic [ACC_W-1:0] y_acc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_v_s3 <= 1'b0;
		end else begin
			y_v_s3 <= sq_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		y_side_s3.neg <= sq_neg_s2;
		y_side_s3.ood <= sq_ood_s2;
		y_side_s3.ax  <= sq_ax_s2;
		y_side_s3.y   <= sq_round[Y_W+3:4];
		y_acc_s3      <= (n_eff == TERM_W'(TERM_LIMIT)) ? COEF_TOP : '0;
	end

	// ------------------------------------------------------------------
	// Horner chain: one unit per coefficient below the top one, from the
	// highest index down to the constant term. Each unit computes
	//   acc = sat(round(acc * y / 2^56)) + c[k-1], saturated to 64 bits,
	// when k is within the term count, and passes zero otherwise (the sum
	// is still zero above the term count, so no bypass of acc is needed).
	// ------------------------------------------------------------------
	logic             v_c    [NUM_STEPS+1];
	side_t            side_c [NUM_STEPS+1];
	logic [ACC_W-1:0] acc_c  [NUM_STEPS+1];

	assign v_c[0]    = y_v_s3;
	assign side_c[0] = y_side_s3;
	assign acc_c[0]  = y_acc_s3;

	for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
		localparam int               K      = TERM_LIMIT - 1 - i;
		localparam logic [ACC_W-1:0] COEF   = coef_fixed(K - 1);
		localparam logic [TERM_W-1:0] K_CODE = TERM_W'(K);
		localparam int               PP_W   = 2 * HALF_W;

		logic                      pp_v_s1;
		side_t                     pp_side_s1;
		logic [2*HALF_W-1:0]       pp00_s1;
		logic [2*HALF_W-1:0]       pp10_s1;
		logic [Y_W-1:0]            pp01_s1;
		logic [Y_W-1:0]            pp11_s1;

		logic                      sm_v_s2;
		side_t                     sm_side_s2;
		logic [SUM_W-1:0]          sm_sum_s2;

		logic                      ac_v_s3;
		side_t                     ac_side_s3;
		logic [ACC_W-1:0]          ac_acc_s3;

		logic                      prod_sat;
		logic [ACC_W-1:0]          prod_rnd;
		logic [ACC_W:0]            coef_add;
		logic [ACC_W-1:0]          acc_next;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pp_v_s1 <= 1'b0;
				sm_v_s2 <= 1'b0;
				ac_v_s3 <= 1'b0;
			end else begin
				pp_v_s1 <= v_c[i];
				sm_v_s2 <= pp_v_s1;
				ac_v_s3 <= sm_v_s2;
			end
		end

		// Four partial products, each at most 32 x 32
		always_ff @(posedge clk) begin
			pp_side_s1 <= side_c[i];
			pp00_s1    <= PP_W'(acc_c[i][HALF_W-1:0])
				* PP_W'(side_c[i].y[HALF_W-1:0]);
			pp01_s1    <= Y_W'(acc_c[i][HALF_W-1:0])
				* Y_W'(side_c[i].y[Y_W-1:HALF_W]);
			pp10_s1    <= PP_W'(acc_c[i][ACC_W-1:HALF_W])
				* PP_W'(side_c[i].y[HALF_W-1:0]);
			pp11_s1    <= Y_W'(acc_c[i][ACC_W-1:HALF_W])
				* Y_W'(side_c[i].y[Y_W-1:HALF_W]);
		end

		// Align and sum, with the rounding half added in
		always_ff @(posedge clk) begin
			sm_side_s2 <= pp_side_s1;
			sm_sum_s2  <= SUM_W'(pp00_s1)
				+ (SUM_W'(pp01_s1) << HALF_W)
				+ (SUM_W'(pp10_s1) << HALF_W)
				+ (SUM_W'(pp11_s1) << (2 * HALF_W))
				+ (SUM_W'(1) << (FRAC_BITS - 1));
		end

		always_comb begin
			prod_sat = |sm_sum_s2[SUM_W-1:FRAC_BITS+ACC_W];
			prod_rnd = prod_sat ? '1 : sm_sum_s2[FRAC_BITS+ACC_W-1:FRAC_BITS];
			coef_add = {1'b0, prod_rnd} + {1'b0, COEF};
			acc_next = coef_add[ACC_W] ? '1 : coef_add[ACC_W-1:0];
		end

		always_ff @(posedge clk) begin
			ac_side_s3 <= sm_side_s2;
			ac_acc_s3  <= (n_eff >= K_CODE) ? acc_next : '0;
		end

		assign v_c[i+1]    = ac_v_s3;
		assign side_c[i+1] = ac_side_s3;
		assign acc_c[i+1]  = ac_acc_s3;
	end

	// ------------------------------------------------------------------
	// Final multiply |x| * acc, rounded to Q10.30. The product stays below
	// 2^95, so only the output range needs saturation.
	// ------------------------------------------------------------------
	logic              f_v_s1;
	logic              f_neg_s1;
	logic              f_ood_s1;
	logic [PROD_W-1:0] f_lo_s1;
	logic [PROD_W-1:0] f_hi_s1;

	logic              f_v_s2;
	logic              f_neg_s2;
	logic              f_ood_s2;
	logic [FSUM_W-1:0] f_sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v_s1 <= 1'b0;
			f_v_s2 <= 1'b0;
		end else begin
			f_v_s1 <= v_c[NUM_STEPS];
			f_v_s2 <= f_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		f_neg_s1 <= side_c[NUM_STEPS].neg;
		f_ood_s1 <= side_c[NUM_STEPS].ood;
		f_lo_s1  <= PROD_W'(side_c[NUM_STEPS].ax)
			* PROD_W'(acc_c[NUM_STEPS][HALF_W-1:0]);
		f_hi_s1  <= PROD_W'(side_c[NUM_STEPS].ax)
			* PROD_W'(acc_c[NUM_STEPS][ACC_W-1:HALF_W]);
	end

	always_ff @(posedge clk) begin
		f_neg_s2 <= f_neg_s1;
		f_ood_s2 <= f_ood_s1;
		f_sum_s2 <= FSUM_W'(f_lo_s1)
			+ (FSUM_W'(f_hi_s1) << HALF_W)
			+ (FSUM_W'(1) << (FRAC_BITS - 1));
	end

	// ------------------------------------------------------------------
	// Output register: clamp the magnitude to the side's limit, apply the
	// sign, and zero the value for an out-of-domain beat.
	// ------------------------------------------------------------------
	logic [TAN_W-1:0] mag;
	logic [TAN_W-1:0] mag_neg;
	logic [TAN_W-1:0] mag_pos;

	always_comb begin
		mag     = f_sum_s2[FRAC_BITS+TAN_W-1:FRAC_BITS];
		mag_neg = (mag > NEG_LIMIT) ? NEG_LIMIT : mag;
		mag_pos = (mag > POS_LIMIT) ? POS_LIMIT : mag;
	end

	logic             done_q;
	logic [TAN_W-1:0] tangent_q;
	logic             ood_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= f_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ood_q <= f_ood_s2;
		if (f_ood_s2) begin
			tangent_q <= '0;
		end else if (f_neg_s2) begin
			tangent_q <= ~mag_neg + TAN_W'(1);
		end else begin
			tangent_q <= mag_pos;
		end
	end

	assign done          = done_q;
	assign tangent       = tangent_q;
	assign out_of_domain = ood_q;

endmodule

`default_nettype wire

/* design/tsa_checker.sv */
// Port-level checker for the tangent series block, bound to the top level.
// Depends on tsa_pkg for the latency and the output width.
`default_nettype none

module tsa_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               start,
	input wire logic                               busy,
	input wire logic signed [tsa_pkg::ANGLE_W-1:0] angle,
	input wire logic                               done,
	input wire logic signed [tsa_pkg::TAN_W-1:0]   tangent,
	input wire logic                               out_of_domain
);
	import tsa_pkg::*;

	// Out-of-domain beats carry a zero value
	a_ood_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_domain |-> tangent == '0)
		else $error("out-of-domain result with nonzero tangent");

	// Every result strobe traces back to an accepted beat
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without an accepted beat");

	// Every accepted beat produces its result after the fixed latency
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted beat lost in the pipeline");

	// A non-negative in-domain angle never yields a negative tangent
	a_sign_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_domain && !$past(angle[ANGLE_W-1], LATENCY) |-> !tangent[TAN_W-1])
		else $error("negative tangent for a non-negative angle");

endmodule

bind tangent_series_approximation tsa_checker u_tsa_checker (.*);

`default_nettype wire
